// ----- sv/arr_pkg.sv -----
// Shared types and constants for the address range registry.
// Used by the top level, the port checker and the testbench.
package arr_pkg;

  localparam int unsigned DEF_MAX_RANGES = 64;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 7;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_QUERY = 3'd4
  } status_t;

endpackage

// ----- sv/arr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth are set by the instantiating module.
module arr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/address_range_registry.sv -----
// Top level of the address range registry: sequencer, table memory and compare unit.
// Depends on arr_pkg and arr_ram.
//
//   channel  ports                                              handshake
//   in       in_command, in_range_base, in_range_size,          start, busy
//            in_query_address
//   out      out_hit, out_status, out_entry_count               out_valid
//
// A word is taken at an edge with start high and busy low.
// It then passes S_PRE, which settles empty ranges, address zero and an empty table,
// and S_SCAN, which walks the stored entries until a match or the last one is tested.
// The table memory is read one entry per cycle and a single subtract-and-compare
// unit tests that entry. The result is shown for one cycle with out_valid high
// and busy low, so the next word may be taken in that cycle; it cannot be stalled.
// Reset clears the entry count; the table itself needs no clearing.
module address_range_registry #(
  parameter int unsigned MAX_RANGES = arr_pkg::DEF_MAX_RANGES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_command,
  input  logic [arr_pkg::ADDR_W-1:0] in_range_base,
  input  logic [arr_pkg::ADDR_W-1:0] in_range_size,
  input  logic [arr_pkg::ADDR_W-1:0] in_query_address,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [2:0]                 out_status,
  output logic [arr_pkg::COUNT_W-1:0] out_entry_count
);

  localparam int unsigned AW    = arr_pkg::ADDR_W;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_SCAN
  } state_t;

  state_t           state_r;
  logic             busy_r;
  logic             out_valid_r;
  logic             out_hit_r;
  arr_pkg::status_t out_status_r;
  logic [CNT_W-1:0] out_count_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] scan_r;
  logic [CNT_W-1:0] scan_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             cmd_r;
  logic [AW-1:0]    base_r;
  logic [AW-1:0]    size_r;
  logic [AW-1:0]    addr_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [2*AW-1:0]  rd_data;
  logic [AW-1:0]    ent_base;
  logic [AW-1:0]    ent_size;
  logic [AW:0]      diff;
  logic             holds;
  logic             dup;
  logic             match;

  logic             dec_done;
  logic             dec_hit;
  logic             dec_append;
  arr_pkg::status_t dec_status;

  arr_ram #(
    .WIDTH (2 * AW),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (dec_append),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data ({base_r, size_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_base = rd_data[2*AW-1:AW];
  assign ent_size = rd_data[AW-1:0];
  assign diff     = {1'b0, addr_r} - {1'b0, ent_base};
  assign holds    = !diff[AW] && (diff[AW-1:0] < ent_size);
  assign dup      = (ent_base == base_r) && (ent_size == size_r);
  assign match    = (cmd_r == arr_pkg::CMD_QUERY) ? holds : dup;
  assign scan_nxt = scan_r + 1'b1;
  assign cnt_nxt  = cnt_r + 1'b1;

  always_comb begin
    dec_done   = 1'b0;
    dec_hit    = 1'b0;
    dec_append = 1'b0;
    dec_status = arr_pkg::ST_QUERY;
    rd_en      = 1'b0;
    rd_addr    = scan_nxt[IDX_W-1:0];
    case (state_r)
      S_PRE: begin
        if (cmd_r == arr_pkg::CMD_REGISTER && (base_r == '0 || size_r == '0)) begin
          dec_done   = 1'b1;
          dec_status = arr_pkg::ST_EMPTY;
        end else if (cmd_r == arr_pkg::CMD_QUERY && addr_r == '0) begin
          dec_done = 1'b1;
        end else if (cnt_r == '0) begin
          dec_done = 1'b1;
          if (cmd_r == arr_pkg::CMD_REGISTER) begin
            dec_append = 1'b1;
            dec_status = arr_pkg::ST_ADDED;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        if (match) begin
          dec_done = 1'b1;
          if (cmd_r == arr_pkg::CMD_QUERY) begin
            dec_hit = 1'b1;
          end else begin
            dec_status = arr_pkg::ST_DUP;
          end
        end else if (scan_nxt == cnt_r) begin
          dec_done = 1'b1;
          if (cmd_r == arr_pkg::CMD_REGISTER) begin
            if (cnt_r == CNT_W'(MAX_RANGES)) begin
              dec_status = arr_pkg::ST_FULL;
            end else begin
              dec_append = 1'b1;
              dec_status = arr_pkg::ST_ADDED;
            end
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_command;
            base_r  <= in_range_base;
            size_r  <= in_range_size;
            addr_r  <= in_query_address;
            busy_r  <= 1'b1;
            state_r <= S_PRE;
          end
        end
        S_PRE, S_SCAN: begin
          if (dec_done) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= dec_hit;
            out_status_r <= dec_status;
            out_count_r  <= dec_append ? cnt_nxt : cnt_r;
            busy_r       <= 1'b0;
            state_r      <= S_IDLE;
            if (dec_append) begin
              cnt_r <= cnt_nxt;
            end
          end else if (state_r == S_PRE) begin
            scan_r  <= '0;
            state_r <= S_SCAN;
          end else begin
            scan_r <= scan_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_entry_count = arr_pkg::COUNT_W'(out_count_r);

endmodule

// ----- sv/arr_checker.sv -----
// Port-level checker for the address range registry, bound to the top level.
// Depends on arr_pkg and on the port list of address_range_registry.
module arr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_hit,
  input logic [2:0]                  out_status,
  input logic [arr_pkg::COUNT_W-1:0] out_entry_count
);

  logic accept;

  assign accept = start && !busy;

  // A taken word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after a word was taken");

  // Busy falls only as a result is shown.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  // Results never come in consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // Only a query answer may report a hit, and only when the table holds an entry.
  a_hit_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == arr_pkg::ST_QUERY && out_entry_count != '0)
    else $error("hit reported outside a query or with an empty table");

endmodule

bind address_range_registry arr_checker u_arr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

// ----- tb/sv/tb_address_range_registry.sv -----
// Self-checking testbench for address_range_registry: directed and random words
// against a behavioural table model, with bursty start and an unstallable result port.
// Depends on arr_pkg and the address_range_registry RTL.
module tb_address_range_registry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = arr_pkg::DEF_MAX_RANGES;
  localparam int RANDOM_WORDS = 1880;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;

  typedef struct {
    logic                       command;
    logic [arr_pkg::ADDR_W-1:0] base;
    logic [arr_pkg::ADDR_W-1:0] size;
    logic [arr_pkg::ADDR_W-1:0] addr;
  } registry_word_t;

  typedef struct {
    logic                        hit;
    arr_pkg::status_t            status;
    logic [arr_pkg::COUNT_W-1:0] count;
  } registry_answer_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = arr_pkg::CMD_REGISTER;
  logic [arr_pkg::ADDR_W-1:0] in_range_base = '0;
  logic [arr_pkg::ADDR_W-1:0] in_range_size = '0;
  logic [arr_pkg::ADDR_W-1:0] in_query_address = '0;
  logic out_valid;
  logic out_hit;
  logic [2:0] out_status;
  logic [arr_pkg::COUNT_W-1:0] out_entry_count;

  registry_word_t   words_pending[$];
  registry_answer_t answers_due[$];
  logic [arr_pkg::ADDR_W-1:0] tried_base[$];
  logic [arr_pkg::ADDR_W-1:0] tried_size[$];

  logic [arr_pkg::ADDR_W-1:0] table_base[TABLE_DEPTH];
  logic [arr_pkg::ADDR_W-1:0] table_size[TABLE_DEPTH];
  int unsigned table_used = 0;

  int words_taken = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 8;
  int gap_left    = 0;
  int status_seen[5] = '{default: 0};
  int hits_seen   = 0;

  address_range_registry u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_range_base    (in_range_base),
    .in_range_size    (in_range_size),
    .in_query_address (in_query_address),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [arr_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [arr_pkg::ADDR_W-1:0] shaped_size();
    int unsigned shift;
    shift = ($urandom_range(0, 99) < 2) ? $urandom_range(0, 3) : $urandom_range(36, 63);
    return rand64() >> shift;
  endfunction

  task automatic add_register(input logic [arr_pkg::ADDR_W-1:0] base,
                              input logic [arr_pkg::ADDR_W-1:0] size);
    registry_word_t w;
    w.command = arr_pkg::CMD_REGISTER;
    w.base    = base;
    w.size    = size;
    w.addr    = rand64();
    words_pending = {words_pending, w};
    if (base != '0 && size != '0) begin
      tried_base = {tried_base, base};
      tried_size = {tried_size, size};
    end
  endtask

  task automatic add_query(input logic [arr_pkg::ADDR_W-1:0] addr);
    registry_word_t w;
    w.command = arr_pkg::CMD_QUERY;
    w.base    = rand64();
    w.size    = rand64();
    w.addr    = addr;
    words_pending = {words_pending, w};
  endtask

  // The range end is formed in 65 bits so that a range reaching past the top
  // of the address space does not wrap round to low addresses.
  function automatic registry_answer_t predict_answer(registry_word_t w);
    registry_answer_t a;
    int unsigned i;
    a.hit = 1'b0;
    if (w.command == arr_pkg::CMD_QUERY) begin
      a.status = arr_pkg::ST_QUERY;
      if (w.addr != '0) begin
        for (i = 0; i < table_used; i++) begin
          if (w.addr >= table_base[i] &&
              {1'b0, w.addr} < {1'b0, table_base[i]} + {1'b0, table_size[i]}) begin
            a.hit = 1'b1;
          end
        end
      end
    end else if (w.base == '0 || w.size == '0) begin
      a.status = arr_pkg::ST_EMPTY;
    end else begin
      a.status = arr_pkg::ST_ADDED;
      for (i = 0; i < table_used; i++) begin
        if (table_base[i] == w.base && table_size[i] == w.size) begin
          a.status = arr_pkg::ST_DUP;
        end
      end
      if (a.status == arr_pkg::ST_ADDED) begin
        if (table_used >= TABLE_DEPTH) begin
          a.status = arr_pkg::ST_FULL;
        end else begin
          table_base[table_used] = w.base;
          table_size[table_used] = w.size;
          table_used++;
        end
      end
    end
    a.count = arr_pkg::COUNT_W'(table_used);
    return a;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : sender
    registry_word_t w;
    logic take;
    take = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (take) begin
        w.command = in_command;
        w.base    = in_range_base;
        w.size    = in_range_size;
        w.addr    = in_query_address;
        answers_due = {answers_due, predict_answer(w)};
        words_taken++;
      end
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (words_pending.size() > 0) begin
          w = words_pending.pop_front();
          in_command       <= w.command;
          in_range_base    <= w.base;
          in_range_size    <= w.size;
          in_query_address <= w.addr;
          start            <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 5);
              8:          gap_left = $urandom_range(6, 30);
              default:    gap_left = $urandom_range(31, 90);
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    registry_answer_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        report("unexpected word, status", 64'(out_status), '0);
      end else begin
        want = answers_due.pop_front();
        status_seen[want.status]++;
        if (want.hit) hits_seen++;
        if (out_hit !== want.hit) report("hit", 64'(out_hit), 64'(want.hit));
        if (out_status !== want.status) begin
          report("status", 64'(out_status), 64'(want.status));
        end
        if (out_entry_count !== want.count) begin
          report("entry_count", 64'(out_entry_count), 64'(want.count));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_address_range_registry failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin : stimulus
    int total_words;
    int n;
    int idx;
    logic [arr_pkg::ADDR_W-1:0] b;
    logic [arr_pkg::ADDR_W-1:0] s;

    add_query('0);
    add_query('1);
    add_register('0, 64'h100);
    add_register(64'h1000, '0);
    add_register('0, '0);
    add_register(64'h1000, 64'h100);
    add_register(64'h1000, 64'h100);
    add_register(64'h1080, 64'h100);
    add_query(64'h1000);
    add_query(64'hfff);
    add_query(64'h117f);
    add_query(64'h1180);
    add_register('1, '1);
    add_register(64'hffff_ffff_ffff_fff0, '1);
    add_query('1);
    add_query(64'hffff_ffff_ffff_ffef);
    add_query(64'h5);
    add_register(64'h1, 64'h1);
    add_query(64'h1);
    add_query(64'h2);
    add_query('0);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:19]: add_register(rand64(), shaped_size());
        [20:24]: begin
          idx = $urandom_range(0, tried_base.size() - 1);
          add_register(tried_base[idx], tried_size[idx]);
        end
        [25:29]: begin
          case ($urandom_range(0, 2))
            0:       add_register('0, rand64());
            1:       add_register(rand64(), '0);
            default: add_register('0, '0);
          endcase
        end
        [30:31]: add_query('0);
        [32:44]: add_query(rand64());
        default: begin
          idx = $urandom_range(0, tried_base.size() - 1);
          b = tried_base[idx];
          s = tried_size[idx];
          case ($urandom_range(0, 4))
            0:       add_query(b);
            1:       add_query(b - 1);
            2:       add_query(b + s - 1);
            3:       add_query(b + s);
            default: add_query(b + (rand64() % s));
          endcase
        end
      endcase
    end
    total_words = words_pending.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words) @(posedge clk);
    while (answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d words: %0d added, %0d duplicates, %0d empty, %0d dropped when full.",
             total_words, status_seen[arr_pkg::ST_ADDED], status_seen[arr_pkg::ST_DUP],
             status_seen[arr_pkg::ST_EMPTY], status_seen[arr_pkg::ST_FULL]);
    $display("Answered %0d queries, %0d of them hits; %0d mismatches.",
             status_seen[arr_pkg::ST_QUERY], hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_address_range_registry passed");
    end else begin
      $display("tb_address_range_registry failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/arr_pkg.sv
sv/arr_ram.sv
sv/address_range_registry.sv
sv/arr_checker.sv
tb/sv/tb_address_range_registry.sv
